### rtl/core/ipbl_pkg.sv
package ipbl_pkg;

  // Host and frame operation codes
  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // Verdict reason codes
  localparam logic [1:0] RSN_OTHER      = 2'd0;
  localparam logic [1:0] RSN_NOT_LISTED = 2'd1;
  localparam logic [1:0] RSN_EXPIRED    = 2'd2;
  localparam logic [1:0] RSN_BLOCKED    = 2'd3;

  // Result kinds
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  // Frame layout
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [5:0]  MIN_FRAME_LEN  = 6'd34;
  localparam logic [5:0]  ETH_HI_POS     = 6'd12;
  localparam logic [5:0]  ETH_LO_POS     = 6'd13;
  localparam logic [5:0]  SRC_FIRST_POS  = 6'd26;
  localparam logic [5:0]  SRC_LAST_POS   = 6'd29;

  // Lookup token that walks the row of slot cells
  typedef struct packed {
    logic        live;
    logic [1:0]  op;
    logic [5:0]  slot;
    logic [31:0] addr;     // source address, or entry address on a write
    logic [63:0] stamp;    // time of the frame, or expiry on a write
    logic        perm;
    logic        hit;
    logic        expired;
    logic [63:0] count;
  } chain_tok_t;

  // Frame parse outcome at the current byte
  typedef struct packed {
    logic        ipv4_ok;
    logic [31:0] src;
  } parse_t;

  // One result transaction
  typedef struct packed {
    logic        kind;
    logic        drop;
    logic [1:0]  reason;
    logic [63:0] drops;
    logic [63:0] total;
    logic [63:0] passed;
    logic [63:0] expired;
    logic [63:0] dropped;
  } result_t;

endpackage

### rtl/core/ipbl_parse.sv
module ipbl_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_en,
  input  logic [7:0]         data_byte,
  input  logic               end_of_packet,
  output ipbl_pkg::parse_t   prs
);

  logic [5:0]  pos;
  logic        eth_ok;
  logic [31:0] src;
  logic [5:0]  pos_next;
  logic        eth_ok_next;
  logic [31:0] src_next;

  // Fold the current byte into the parse state
  always_comb begin
    eth_ok_next = eth_ok;
    src_next    = src;
    if (pos == ipbl_pkg::ETH_HI_POS) begin
      eth_ok_next = (data_byte == ipbl_pkg::ETHERTYPE_IPV4[15:8]);
    end else if (pos == ipbl_pkg::ETH_LO_POS) begin
      eth_ok_next = eth_ok && (data_byte == ipbl_pkg::ETHERTYPE_IPV4[7:0]);
    end else if (pos >= ipbl_pkg::SRC_FIRST_POS && pos <= ipbl_pkg::SRC_LAST_POS) begin
      src_next = {src[23:0], data_byte};
    end
    pos_next = (pos < ipbl_pkg::MIN_FRAME_LEN) ? pos + 6'd1 : pos;
  end

  assign prs.ipv4_ok = (pos_next == ipbl_pkg::MIN_FRAME_LEN) && eth_ok_next;
  assign prs.src     = src_next;

  // Advance on each byte, clear at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      eth_ok <= 1'b0;
      src    <= '0;
    end else if (byte_en) begin
      if (end_of_packet) begin
        pos    <= '0;
        eth_ok <= 1'b0;
        src    <= '0;
      end else begin
        pos    <= pos_next;
        eth_ok <= eth_ok_next;
        src    <= src_next;
      end
    end
  end

endmodule

### rtl/core/ipbl_cell.sv
module ipbl_cell #(
  parameter int unsigned SLOT = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ipbl_pkg::chain_tok_t   tok_in,
  output ipbl_pkg::chain_tok_t   tok_out
);

  logic        valid;
  logic [31:0] addr_q;
  logic        perm_q;
  logic [63:0] exp_q;
  logic [63:0] count_q;

  ipbl_pkg::chain_tok_t nxt;
  logic        sel;
  logic        match;
  logic        late;
  logic [63:0] bump;

  // Compare the passing token against this slot
  always_comb begin
    nxt   = tok_in;
    sel   = (32'(tok_in.slot) == 32'(SLOT));
    match = valid && (addr_q == tok_in.addr) && !tok_in.hit;
    late  = !perm_q && (exp_q != 64'd0) && (tok_in.stamp > exp_q);
    bump  = count_q + 64'd1;
    if (tok_in.live) begin
      case (tok_in.op)
        ipbl_pkg::OP_BYTE: begin
          if (match) begin
            nxt.hit     = 1'b1;
            nxt.expired = late;
            nxt.count   = late ? count_q : bump;
          end
        end
        ipbl_pkg::OP_READ: begin
          if (sel) begin
            nxt.count = count_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hand the token on and update slot control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= 1'b0;
      count_q      <= '0;
      tok_out.live <= 1'b0;
    end else begin
      tok_out <= nxt;
      if (tok_in.live) begin
        case (tok_in.op)
          ipbl_pkg::OP_BYTE: begin
            if (match && !late) begin
              count_q <= bump;
            end
          end
          ipbl_pkg::OP_WRITE: begin
            if (sel) begin
              valid   <= 1'b1;
              count_q <= '0;
            end
          end
          ipbl_pkg::OP_REMOVE: begin
            if (sel) begin
              valid <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Load the entry on a write
  always_ff @(posedge clk) begin
    if (tok_in.live && (tok_in.op == ipbl_pkg::OP_WRITE) && sel) begin
      addr_q <= tok_in.addr;
      perm_q <= tok_in.perm;
      exp_q  <= tok_in.stamp;
    end
  end

endmodule

### rtl/core/ipv4_source_blocklist_filter_core.sv
// A non-final frame byte gives no result; a final byte of a short or non-IPv4 frame gives
// its verdict without the cell row. Lookups and host operations walk the row of TABLE_DEPTH
// slot cells, one cell per cycle. Every result passes the pending and output registers.
// Throughput: one frame byte per cycle inside a frame while input is not stalled; a table
// operation blocks input until its token leaves the row and any pending result moves on.
// Synchronous reset clears all slots invalid.
module ipv4_source_blocklist_filter_core #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  data_byte,
  input  logic        end_of_packet,
  input  logic [63:0] time_now,
  input  logic [5:0]  slot_index,
  input  logic [31:0] entry_address,
  input  logic        entry_permanent,
  input  logic [63:0] entry_expiry,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic        drop_frame,
  output logic [1:0]  verdict_reason,
  output logic [63:0] slot_drops,
  output logic [63:0] total_frames,
  output logic [63:0] passed_frames,
  output logic [63:0] expired_frames,
  output logic [63:0] dropped_frames
);

  logic in_accept;
  logic is_byte;
  logic byte_en;
  logic launch;
  logic quick;
  logic busy;
  logic pend_valid;
  logic out_free;
  logic res_load;

  ipbl_pkg::parse_t     prs;
  ipbl_pkg::chain_tok_t launch_tok;
  ipbl_pkg::chain_tok_t tok [TABLE_DEPTH];
  ipbl_pkg::chain_tok_t tail;
  ipbl_pkg::result_t    res;
  ipbl_pkg::result_t    pend;
  ipbl_pkg::result_t    out_q;

  logic [63:0] cnt_total;
  logic [63:0] cnt_passed;
  logic [63:0] cnt_expired;
  logic [63:0] cnt_dropped;
  logic [63:0] cnt_total_next;
  logic [63:0] cnt_passed_next;
  logic [63:0] cnt_expired_next;
  logic [63:0] cnt_dropped_next;

  // Input handshake: one table operation at a time
  assign in_stall  = busy || pend_valid;
  assign in_accept = in_valid && !in_stall;
  assign is_byte   = (opcode == ipbl_pkg::OP_BYTE);
  assign byte_en   = in_accept && is_byte;
  assign launch    = in_accept && (!is_byte || (end_of_packet && prs.ipv4_ok));
  assign quick     = byte_en && end_of_packet && !prs.ipv4_ok;

  ipbl_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .byte_en       (byte_en),
    .data_byte     (data_byte),
    .end_of_packet (end_of_packet),
    .prs           (prs)
  );

  // Build the token that enters the first cell
  always_comb begin
    launch_tok         = '0;
    launch_tok.live    = launch;
    launch_tok.op      = opcode;
    launch_tok.slot    = slot_index;
    launch_tok.addr    = is_byte ? prs.src : entry_address;
    launch_tok.stamp   = is_byte ? time_now : entry_expiry;
    launch_tok.perm    = entry_permanent;
  end

  // Row of slot cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      ipbl_cell #(.SLOT(i)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .tok_in  (launch_tok),
        .tok_out (tok[i])
      );
    end else begin : g_body
      ipbl_cell #(.SLOT(i)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .tok_in  (tok[i-1]),
        .tok_out (tok[i])
      );
    end
  end

  assign tail = tok[TABLE_DEPTH-1];

  // Form the result and advance the frame counters
  always_comb begin
    cnt_total_next   = cnt_total;
    cnt_passed_next  = cnt_passed;
    cnt_expired_next = cnt_expired;
    cnt_dropped_next = cnt_dropped;
    res              = '0;
    res_load         = 1'b0;
    if (quick) begin
      cnt_total_next  = cnt_total + 64'd1;
      cnt_passed_next = cnt_passed + 64'd1;
      res.kind        = ipbl_pkg::KIND_VERDICT;
      res.reason      = ipbl_pkg::RSN_OTHER;
      res_load        = 1'b1;
    end else if (tail.live) begin
      case (tail.op)
        ipbl_pkg::OP_BYTE: begin
          cnt_total_next = cnt_total + 64'd1;
          res.kind       = ipbl_pkg::KIND_VERDICT;
          res_load       = 1'b1;
          if (!tail.hit) begin
            cnt_passed_next = cnt_passed + 64'd1;
            res.reason      = ipbl_pkg::RSN_NOT_LISTED;
          end else if (tail.expired) begin
            cnt_expired_next = cnt_expired + 64'd1;
            res.reason       = ipbl_pkg::RSN_EXPIRED;
            res.drops        = tail.count;
          end else begin
            cnt_dropped_next = cnt_dropped + 64'd1;
            res.reason       = ipbl_pkg::RSN_BLOCKED;
            res.drop         = 1'b1;
            res.drops        = tail.count;
          end
        end
        ipbl_pkg::OP_READ: begin
          res.kind  = ipbl_pkg::KIND_READ;
          res.drops = tail.count;
          res_load  = 1'b1;
        end
        default: begin
        end
      endcase
    end
    res.total   = cnt_total_next;
    res.passed  = cnt_passed_next;
    res.expired = cnt_expired_next;
    res.dropped = cnt_dropped_next;
  end

  assign out_free = !out_valid || !out_stall;

  // Track the lookup in flight, hold the pending result, drive the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
      cnt_total   <= '0;
      cnt_passed  <= '0;
      cnt_expired <= '0;
      cnt_dropped <= '0;
    end else begin
      cnt_total   <= cnt_total_next;
      cnt_passed  <= cnt_passed_next;
      cnt_expired <= cnt_expired_next;
      cnt_dropped <= cnt_dropped_next;
      if (launch) begin
        busy <= 1'b1;
      end else if (tail.live) begin
        busy <= 1'b0;
      end
      if (res_load) begin
        pend_valid <= 1'b1;
      end else if (pend_valid && out_free) begin
        pend_valid <= 1'b0;
      end
      if (out_free) begin
        out_valid <= pend_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      pend <= res;
    end
    if (out_free && pend_valid) begin
      out_q <= pend;
    end
  end

  assign result_kind    = out_q.kind;
  assign drop_frame     = out_q.drop;
  assign verdict_reason = out_q.reason;
  assign slot_drops     = out_q.drops;
  assign total_frames   = out_q.total;
  assign passed_frames  = out_q.passed;
  assign expired_frames = out_q.expired;
  assign dropped_frames = out_q.dropped;

`ifndef NO_ASSERTIONS
  a_tail_needs_busy: assert property (@(posedge clk) disable iff (rst)
    tail.live |-> busy)
    else $error("token left the cell row with no lookup in flight");

  a_pend_not_busy: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> !busy)
    else $error("pending result while a lookup is still in flight");

  a_total_steps: assert property (@(posedge clk) disable iff (rst)
    (tail.live && (tail.op == ipbl_pkg::OP_BYTE)) |=> (cnt_total == $past(cnt_total) + 64'd1))
    else $error("frame verdict did not advance the total counter");
`endif

endmodule

### tb/ipv4_source_blocklist_filter_core_tb.sv
module ipv4_source_blocklist_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes and frame layout taken from the package
  localparam logic [1:0]  OP_BYTE        = ipbl_pkg::OP_BYTE;
  localparam logic [1:0]  OP_WRITE       = ipbl_pkg::OP_WRITE;
  localparam logic [1:0]  OP_REMOVE      = ipbl_pkg::OP_REMOVE;
  localparam logic [1:0]  OP_READ        = ipbl_pkg::OP_READ;
  localparam logic [1:0]  RSN_OTHER      = ipbl_pkg::RSN_OTHER;
  localparam logic [1:0]  RSN_NOT_LISTED = ipbl_pkg::RSN_NOT_LISTED;
  localparam logic [1:0]  RSN_EXPIRED    = ipbl_pkg::RSN_EXPIRED;
  localparam logic [1:0]  RSN_BLOCKED    = ipbl_pkg::RSN_BLOCKED;
  localparam logic        KIND_VERDICT   = ipbl_pkg::KIND_VERDICT;
  localparam logic        KIND_READ      = ipbl_pkg::KIND_READ;
  localparam logic [15:0] ETHERTYPE_IPV4 = ipbl_pkg::ETHERTYPE_IPV4;
  localparam logic [5:0]  MIN_FRAME_LEN  = ipbl_pkg::MIN_FRAME_LEN;
  localparam logic [5:0]  ETH_HI_POS     = ipbl_pkg::ETH_HI_POS;
  localparam logic [5:0]  ETH_LO_POS     = ipbl_pkg::ETH_LO_POS;
  localparam logic [5:0]  SRC_FIRST_POS  = ipbl_pkg::SRC_FIRST_POS;
  localparam logic [5:0]  SRC_LAST_POS   = ipbl_pkg::SRC_LAST_POS;

  typedef ipbl_pkg::result_t result_t;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [63:0] T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  // One directed step: OP_BYTE stands for a whole frame, other codes for one host op
  typedef struct packed {
    logic [1:0]  op;
    logic [6:0]  len;
    logic [15:0] etype;
    logic [31:0] src;
    logic [63:0] now;
    logic [5:0]  slot;       // host op slot, or slot read inside the frame
    logic [31:0] addr;
    logic        perm;
    logic [63:0] expiry;
    logic        mid_read;   // read the slot while the source address is partly parsed
    logic        typed;      // verdict below is known by hand
    logic        drop;
    logic [1:0]  reason;
    logic [63:0] drops;
  } plan_row_t;

  localparam plan_row_t DIRECTED_PLAN [24] = '{
    // reads straight after reset
    '{OP_READ, 7'd0, 16'h0, 32'h0, 64'd0, 6'd0, 32'h0, 1'b0, 64'd0,
      1'b0, 1'b1, 1'b0, RSN_OTHER, 64'd0},
    '{OP_READ, 7'd0, 16'h0, 32'h0, 64'd0, 6'd63, 32'h0, 1'b0, 64'd0,
      1'b0, 1'b1, 1'b0, RSN_OTHER, 64'd0},
    // short frames and foreign ethertypes
    '{OP_BYTE, 7'd1, ETHERTYPE_IPV4, 32'h0, 64'd0, 6'd0, 32'h0, 1'b0, 64'd0,
      1'b0, 1'b1, 1'b0, RSN_OTHER, 64'd0},
    '{OP_BYTE, 7'd33, ETHERTYPE_IPV4, 32'h0A00_0001, 64'd0, 6'd0, 32'h0, 1'b0, 64'd0,
      1'b0, 1'b1, 1'b0, RSN_OTHER, 64'd0},
    '{OP_BYTE, 7'd34, 16'h0801, 32'h0A00_0001, 64'd0, 6'd0, 32'h0, 1'b0, 64'd0,
      1'b0, 1'b1, 1'b0, RSN_OTHER, 64'd0},
    '{OP_BYTE, 7'd40, 16'h0900, 32'h0A00_0001, 64'd0, 6'd0, 32'h0, 1'b0, 64'd0,
      1'b0, 1'b1, 1'b0, RSN_OTHER, 64'd0},
    // empty table
    '{OP_BYTE, 7'd34, ETHERTYPE_IPV4, 32'h0A00_0001, 64'd0, 6'd0, 32'h0, 1'b0, 64'd0,
      1'b0, 1'b1, 1'b0, RSN_NOT_LISTED, 64'd0},
    // permanent entry in the top slot, long frame at the latest time
    '{OP_WRITE, 7'd0, 16'h0, 32'h0, 64'd0, 6'd63, 32'hFFFF_FFFF, 1'b1, 64'd0,
      1'b0, 1'b0, 1'b0, RSN_OTHER, 64'd0},
    '{OP_BYTE, 7'd64, ETHERTYPE_IPV4, 32'hFFFF_FFFF, T_MAX, 6'd0, 32'h0, 1'b0, 64'd0,
      1'b0, 1'b1, 1'b1, RSN_BLOCKED, 64'd1},
    // expiring entry: at the expiry time it still blocks, one ns later it has lapsed
    '{OP_WRITE, 7'd0, 16'h0, 32'h0, 64'd0, 6'd5, 32'h0, 1'b0, 64'd1000,
      1'b0, 1'b0, 1'b0, RSN_OTHER, 64'd0},
    '{OP_BYTE, 7'd34, ETHERTYPE_IPV4, 32'h0, 64'd1000, 6'd0, 32'h0, 1'b0, 64'd0,
      1'b0, 1'b1, 1'b1, RSN_BLOCKED, 64'd1},
    '{OP_BYTE, 7'd34, ETHERTYPE_IPV4, 32'h0, 64'd1001, 6'd0, 32'h0, 1'b0, 64'd0,
      1'b0, 1'b1, 1'b0, RSN_EXPIRED, 64'd1},
    // same address in a lower slot with no expiry wins
    '{OP_WRITE, 7'd0, 16'h0, 32'h0, 64'd0, 6'd0, 32'h0, 1'b0, 64'd0,
      1'b0, 1'b0, 1'b0, RSN_OTHER, 64'd0},
    '{OP_BYTE, 7'd34, ETHERTYPE_IPV4, 32'h0, T_MAX, 6'd0, 32'h0, 1'b0, 64'd0,
      1'b0, 1'b1, 1'b1, RSN_BLOCKED, 64'd1},
    '{OP_READ, 7'd0, 16'h0, 32'h0, 64'd0, 6'd5, 32'h0, 1'b0, 64'd0,
      1'b0, 1'b1, 1'b0, RSN_OTHER, 64'd1},
    // remove hands the address back to the higher slot; count stays readable
    '{OP_REMOVE, 7'd0, 16'h0, 32'h0, 64'd0, 6'd0, 32'h0, 1'b0, 64'd0,
      1'b0, 1'b0, 1'b0, RSN_OTHER, 64'd0},
    '{OP_BYTE, 7'd34, ETHERTYPE_IPV4, 32'h0, 64'd500, 6'd0, 32'h0, 1'b0, 64'd0,
      1'b0, 1'b1, 1'b1, RSN_BLOCKED, 64'd2},
    '{OP_READ, 7'd0, 16'h0, 32'h0, 64'd0, 6'd0, 32'h0, 1'b0, 64'd0,
      1'b0, 1'b1, 1'b0, RSN_OTHER, 64'd1},
    // rewrite clears the count
    '{OP_WRITE, 7'd0, 16'h0, 32'h0, 64'd0, 6'd5, 32'hC0A8_0001, 1'b0, T_MAX,
      1'b0, 1'b0, 1'b0, RSN_OTHER, 64'd0},
    '{OP_READ, 7'd0, 16'h0, 32'h0, 64'd0, 6'd5, 32'h0, 1'b0, 64'd0,
      1'b0, 1'b1, 1'b0, RSN_OTHER, 64'd0},
    // host read in the middle of the source address
    '{OP_BYTE, 7'd50, ETHERTYPE_IPV4, 32'hC0A8_0001, T_MAX, 6'd63, 32'h0, 1'b0, 64'd0,
      1'b1, 1'b0, 1'b0, RSN_OTHER, 64'd0},
    // permanent flag overrides a past expiry
    '{OP_WRITE, 7'd0, 16'h0, 32'h0, 64'd0, 6'd7, 32'h0A00_0001, 1'b1, 64'd5,
      1'b0, 1'b0, 1'b0, RSN_OTHER, 64'd0},
    '{OP_BYTE, 7'd34, ETHERTYPE_IPV4, 32'h0A00_0001, T_MAX, 6'd0, 32'h0, 1'b0, 64'd0,
      1'b0, 1'b1, 1'b1, RSN_BLOCKED, 64'd1},
    // right high ethertype byte, wrong low byte
    '{OP_BYTE, 7'd34, 16'h0808, 32'h0A00_0001, 64'd0, 6'd0, 32'h0, 1'b0, 64'd0,
      1'b0, 1'b1, 1'b0, RSN_OTHER, 64'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = OP_BYTE;
  logic [7:0]  data_byte = '0;
  logic        end_of_packet = 1'b0;
  logic [63:0] time_now = '0;
  logic [5:0]  slot_index = '0;
  logic [31:0] entry_address = '0;
  logic        entry_permanent = 1'b0;
  logic [63:0] entry_expiry = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        result_kind;
  logic        drop_frame;
  logic [1:0]  verdict_reason;
  logic [63:0] slot_drops;
  logic [63:0] total_frames;
  logic [63:0] passed_frames;
  logic [63:0] expired_frames;
  logic [63:0] dropped_frames;

  // Predicted filter state
  logic [5:0]  parse_pos;
  logic        ipv4_seen;
  logic [31:0] parse_src;
  logic        blk_valid [TABLE_DEPTH];
  logic [31:0] blk_addr [TABLE_DEPTH];
  logic        blk_perm [TABLE_DEPTH];
  logic [63:0] blk_expiry [TABLE_DEPTH];
  logic [63:0] blk_drops [TABLE_DEPTH];
  logic [63:0] cnt_total, cnt_passed, cnt_expired, cnt_dropped;

  result_t     expected_results [$];
  logic [31:0] addr_pool [8];
  int          error_count = 0;
  int          items_sent = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  int          mid_op_pct = 0;
  int          stall_left = 0;
  int unsigned cycle_count = 0;

  ipv4_source_blocklist_filter_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .data_byte(data_byte),
    .end_of_packet(end_of_packet),
    .time_now(time_now),
    .slot_index(slot_index),
    .entry_address(entry_address),
    .entry_permanent(entry_permanent),
    .entry_expiry(entry_expiry),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_kind(result_kind),
    .drop_frame(drop_frame),
    .verdict_reason(verdict_reason),
    .slot_drops(slot_drops),
    .total_frames(total_frames),
    .passed_frames(passed_frames),
    .expired_frames(expired_frames),
    .dropped_frames(dropped_frames)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < 40) $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Advance the predicted filter by one accepted transaction
  task automatic filter_predict(input logic [1:0] op, input logic [7:0] b, input logic eop,
                                input logic [63:0] now, input logic [5:0] idx,
                                input logic [31:0] addr, input logic perm,
                                input logic [63:0] expiry);
    result_t r;
    logic    emit;
    int      hit;
    int      i;
    r = '0;
    emit = 1'b0;
    case (op)
      OP_BYTE: begin
        if (parse_pos == ETH_HI_POS) begin
          ipv4_seen = (b == ETHERTYPE_IPV4[15:8]);
        end else if (parse_pos == ETH_LO_POS) begin
          ipv4_seen = ipv4_seen && (b == ETHERTYPE_IPV4[7:0]);
        end else if (parse_pos >= SRC_FIRST_POS && parse_pos <= SRC_LAST_POS) begin
          parse_src = {parse_src[23:0], b};
        end
        if (parse_pos < MIN_FRAME_LEN) parse_pos++;
        if (eop) begin
          emit = 1'b1;
          r.kind = KIND_VERDICT;
          cnt_total++;
          if (parse_pos < MIN_FRAME_LEN || !ipv4_seen) begin
            cnt_passed++;
            r.reason = RSN_OTHER;
          end else begin
            // lowest valid slot with this address wins
            hit = -1;
            for (i = TABLE_DEPTH - 1; i >= 0; i--) begin
              if (blk_valid[i] && blk_addr[i] == parse_src) hit = i;
            end
            if (hit < 0) begin
              cnt_passed++;
              r.reason = RSN_NOT_LISTED;
            end else if (!blk_perm[hit] && blk_expiry[hit] != 0 && now > blk_expiry[hit]) begin
              cnt_expired++;
              r.reason = RSN_EXPIRED;
              r.drops = blk_drops[hit];
            end else begin
              blk_drops[hit]++;
              cnt_dropped++;
              r.drop = 1'b1;
              r.reason = RSN_BLOCKED;
              r.drops = blk_drops[hit];
            end
          end
          parse_pos = '0;
          ipv4_seen = 1'b0;
          parse_src = '0;
        end
      end
      OP_WRITE: begin
        blk_valid[idx] = 1'b1;
        blk_addr[idx] = addr;
        blk_perm[idx] = perm;
        blk_expiry[idx] = expiry;
        blk_drops[idx] = '0;
      end
      OP_REMOVE: begin
        blk_valid[idx] = 1'b0;
      end
      default: begin
        emit = 1'b1;
        r.kind = KIND_READ;
        r.reason = RSN_OTHER;
        r.drops = blk_drops[idx];
      end
    endcase
    if (emit) begin
      r.total = cnt_total;
      r.passed = cnt_passed;
      r.expired = cnt_expired;
      r.dropped = cnt_dropped;
      expected_results.push_back(r);
    end
  endtask

  // Present one transaction at a falling edge and hold it until accepted
  task automatic drive_item(input logic [1:0] op, input logic [7:0] b, input logic eop,
                            input logic [63:0] now, input logic [5:0] idx,
                            input logic [31:0] addr, input logic perm,
                            input logic [63:0] expiry);
    if ($urandom_range(0, 99) < in_idle_pct) repeat ($urandom_range(1, 10)) @(negedge clk);
    opcode = op;
    data_byte = b;
    end_of_packet = eop;
    time_now = now;
    slot_index = idx;
    entry_address = addr;
    entry_permanent = perm;
    entry_expiry = expiry;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    filter_predict(op, b, eop, now, idx, addr, perm, expiry);
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [63:0] pick_time();
    case ($urandom_range(0, 7))
      0: pick_time = '0;
      1: pick_time = T_MAX;
      2: pick_time = {$urandom, $urandom};
      default: pick_time = 64'($urandom_range(0, 3000));
    endcase
  endfunction

  // Write, remove or read a slot, mostly among the low slots and pooled addresses
  task automatic random_host_op();
    int unsigned sel;
    logic [1:0]  op;
    logic [5:0]  idx;
    logic [31:0] addr;
    sel = $urandom_range(0, 9);
    op = (sel < 5) ? OP_WRITE : ((sel < 7) ? OP_REMOVE : OP_READ);
    idx = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 7)) : 6'($urandom);
    addr = ($urandom_range(0, 4) != 0) ? addr_pool[$urandom_range(0, 7)] : $urandom;
    drive_item(op, 8'($urandom), 1'($urandom), {$urandom, $urandom}, idx, addr,
               $urandom_range(0, 3) == 0, pick_time());
  endtask

  // Stream one frame; host ops may cut in between its bytes
  task automatic send_frame(input int len, input logic [15:0] etype, input logic [31:0] src,
                            input logic [63:0] now, input int mid_pos,
                            input logic [5:0] mid_slot);
    logic [7:0] b;
    logic       last;
    int         p;
    for (p = 0; p < len; p++) begin
      if (p == mid_pos) begin
        drive_item(OP_READ, 8'($urandom), 1'b0, {$urandom, $urandom}, mid_slot, $urandom,
                   1'($urandom), {$urandom, $urandom});
      end else if (p > 0 && $urandom_range(0, 99) < mid_op_pct) begin
        random_host_op();
      end
      case (p)
        12: b = etype[15:8];
        13: b = etype[7:0];
        26, 27, 28, 29: b = src[8 * (29 - p) +: 8];
        default: b = 8'($urandom);
      endcase
      last = (p == len - 1);
      drive_item(OP_BYTE, b, last, last ? now : {$urandom, $urandom}, 6'($urandom), $urandom,
                 1'($urandom), {$urandom, $urandom});
    end
  endtask

  task automatic random_frame();
    int unsigned sel;
    int          len;
    logic [15:0] etype;
    logic [31:0] src;
    sel = $urandom_range(0, 19);
    etype = ETHERTYPE_IPV4;
    len = 34 + $urandom_range(0, 6);
    if (sel == 0) begin
      len = $urandom_range(1, 33);
    end else if (sel == 1) begin
      etype = ETHERTYPE_IPV4 ^ 16'($urandom_range(1, 16'hFFFF));
    end else if (sel == 2) begin
      len = $urandom_range(41, 80);
    end
    src = ($urandom_range(0, 3) != 0) ? addr_pool[$urandom_range(0, 7)] : $urandom;
    send_frame(len, etype, src, pick_time(), -1, '0);
  endtask

  // Stall the result side in bursts of random length
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(0, 9);
    end else begin
      out_stall = 1'b0;
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transaction with no prediction waiting");
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", 64'(result_kind), 64'(want.kind));
        check_field("drop_frame", 64'(drop_frame), 64'(want.drop));
        check_field("verdict_reason", 64'(verdict_reason), 64'(want.reason));
        check_field("slot_drops", slot_drops, want.drops);
        check_field("total_frames", total_frames, want.total);
        check_field("passed_frames", passed_frames, want.passed);
        check_field("expired_frames", expired_frames, want.expired);
        check_field("dropped_frames", dropped_frames, want.dropped);
      end
    end
  end

  // Bound the run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ipv4_source_blocklist_filter_core_tb NOT OK");
    $finish;
  end

  initial begin
    plan_row_t row;
    result_t   typed_res;
    int        episode;
    parse_pos = '0;
    ipv4_seen = 1'b0;
    parse_src = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      blk_valid[i] = 1'b0;
      blk_addr[i] = '0;
      blk_perm[i] = 1'b0;
      blk_expiry[i] = '0;
      blk_drops[i] = '0;
    end
    cnt_total = '0;
    cnt_passed = '0;
    cnt_expired = '0;
    cnt_dropped = '0;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) addr_pool[i] = $urandom;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the directed plan with light idling on both sides
    in_idle_pct = 15;
    out_stall_pct = 15;
    for (int n = 0; n < $size(DIRECTED_PLAN); n++) begin
      row = DIRECTED_PLAN[n];
      if (row.op == OP_BYTE) begin
        send_frame(int'(row.len), row.etype, row.src, row.now, row.mid_read ? 27 : -1,
                   row.slot);
      end else begin
        drive_item(row.op, 8'h00, 1'b0, 64'd0, row.slot, row.addr, row.perm, row.expiry);
      end
      // hand-known verdict replaces the predicted one
      if (row.typed) begin
        typed_res = expected_results[expected_results.size() - 1];
        typed_res.kind = (row.op == OP_READ) ? KIND_READ : KIND_VERDICT;
        typed_res.drop = row.drop;
        typed_res.reason = row.reason;
        typed_res.drops = row.drops;
        expected_results[expected_results.size() - 1] = typed_res;
      end
    end

    // Random frames and host ops, pacing changed every six episodes
    mid_op_pct = 3;
    episode = 0;
    while (items_sent < 600) begin
      if (episode % 6 == 0) begin
        in_idle_pct = 15 * $urandom_range(0, 2);
        out_stall_pct = 15 * $urandom_range(0, 2);
      end
      if ($urandom_range(0, 99) < 35) random_host_op();
      else random_frame();
      episode++;
    end

    // Finish at full rate
    in_idle_pct = 0;
    out_stall_pct = 0;
    repeat (4) begin
      random_host_op();
      random_frame();
    end

    while (expected_results.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 16) @(posedge clk);
    if (error_count == 0) begin
      $display("ipv4_source_blocklist_filter_core_tb OK");
    end else begin
      $display("ipv4_source_blocklist_filter_core_tb NOT OK");
    end
    $finish;
  end

endmodule
